/* design/psrt_pkg.sv */
// Shared constants and types for the packet sequence reorder tracker.
`default_nettype none

package psrt_pkg;

  localparam int NUM_CONN = 16;
  localparam int WINDOW   = 64;

  localparam int CONN_W  = $clog2(NUM_CONN);
  localparam int IDX_W   = $clog2(WINDOW);
  localparam int RUN_W   = $clog2(WINDOW + 1);
  localparam int SHIFT_W = RUN_W + 1;

  localparam int SEQ_W    = 32;
  localparam int STATUS_W = 3;
  localparam int TOL_W    = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [STATUS_W-1:0] ST_ACCEPTED      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ACCEPTED_LATE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RESYNC        = 3'd3;
  localparam logic [STATUS_W-1:0] ST_REORDERED     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_TOO_FAR       = 3'd5;

  localparam logic OP_VALIDATE = 1'b0;
  localparam logic OP_RESET    = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RESYNC_GAP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REORDER_TOLERANCE = 2'd1;

  localparam logic [SEQ_W-1:0] RESYNC_GAP_RESET = 32'd1024;
  localparam logic [TOL_W-1:0] TOLERANCE_RESET  = 7'd32;

  typedef struct packed {
    logic [SEQ_W-1:0]  expected;
    logic [SEQ_W-1:0]  highest;
    logic [WINDOW-1:0] pending;
  } conn_state_t;

endpackage

`default_nettype wire

/* design/packet_sequence_reorder_tracker_core.sv */
// Top level of the per-connection packet sequence reorder tracker.
// Usage:
//   Input channel (in_valid/in_ready) carries op, connection and seq_num.
//   Each transfer produces exactly one result on the output channel
//   (out_valid/out_ready): status, expected_next and highest_seen.
//   Config channel (cfg_valid/cfg_ready) writes max_resync_gap (index 0) or
//   reorder_tolerance (index 1); other indexes are ignored. cfg_ready is
//   always high; write only while no item is in flight.
// Timing:
//   An item is held in the input register, where the state lookup,
//   window scan and update are done, then lands in the result register,
//   which drives out_valid. Throughput is one item per cycle while
//   out_ready stays high, including back-to-back items on the same
//   connection, since the state table is written at the same edge that
//   loads the result register.
// Reset and stall:
//   Synchronous active-low reset clears all connection state and loads the
//   default config values. While the receiver holds out_ready low, the result
//   register holds, one more item can wait in the input register, and then
//   in_ready drops until the result is taken.
`default_nettype none

module packet_sequence_reorder_tracker_core (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_valid,
  output logic                               in_ready,
  input  wire                                in_op,
  input  wire  [3:0]                         in_connection,
  input  wire  [psrt_pkg::SEQ_W-1:0]         in_seq_num,
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic [psrt_pkg::STATUS_W-1:0]      out_status,
  output logic [psrt_pkg::SEQ_W-1:0]         out_expected_next,
  output logic [psrt_pkg::SEQ_W-1:0]         out_highest_seen,
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire  [psrt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [psrt_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import psrt_pkg::*;

  // Configuration registers.
  logic [SEQ_W-1:0] max_gap_r;
  logic [TOL_W-1:0] tol_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_gap_r <= RESYNC_GAP_RESET;
      tol_r     <= TOLERANCE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MAX_RESYNC_GAP:    max_gap_r <= cfg_data;
        CFG_REORDER_TOLERANCE: tol_r     <= cfg_data[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register.
  logic              s1_valid_r;
  logic              s1_op_r;
  logic [CONN_W-1:0] s1_conn_r;
  logic [SEQ_W-1:0]  s1_seq_r;

  logic advance;
  logic s1_fire;

  assign advance  = !out_valid || out_ready;
  assign s1_fire  = s1_valid_r && advance;
  assign in_ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op_r   <= in_op;
      s1_conn_r <= in_connection[CONN_W-1:0];
      s1_seq_r  <= in_seq_num;
    end
  end

  // Connection state table.
  conn_state_t state_r [NUM_CONN];
  conn_state_t cur;
  conn_state_t state_nxt;

  assign cur = state_r[s1_conn_r];

  // Length of the run of pending arrivals right after expected: the index of
  // the lowest clear bit, found from an isolated one-hot mask.
  logic [WINDOW-1:0] pend_inv;
  logic [WINDOW-1:0] low_zero;
  logic [RUN_W-1:0]  run;

  assign pend_inv = ~cur.pending;
  assign low_zero = pend_inv & (~pend_inv + {{(WINDOW-1){1'b0}}, 1'b1});

  always_comb begin
    run = '0;
    for (int i = 0; i < WINDOW; i++) begin
      if (low_zero[i]) run = run | RUN_W'(i);
    end
    if (pend_inv == '0) run = RUN_W'(WINDOW);
  end

  logic [SHIFT_W-1:0] shift_amt;
  logic [TOL_W-1:0]   tol_eff;
  logic [SEQ_W-1:0]   gap;
  logic [SEQ_W-1:0]   gap_m1;
  logic [IDX_W-1:0]   gap_idx;
  logic [SEQ_W-1:0]   seq_max;
  logic [STATUS_W-1:0] status_nxt;

  assign shift_amt = {1'b0, run} + {{RUN_W{1'b0}}, 1'b1};
  assign tol_eff   = (tol_r > TOL_W'(WINDOW)) ? TOL_W'(WINDOW) : tol_r;
  assign gap       = s1_seq_r - cur.expected;
  assign gap_m1    = gap - 32'd1;
  assign gap_idx   = gap_m1[IDX_W-1:0];
  assign seq_max   = (s1_seq_r > cur.highest) ? s1_seq_r : cur.highest;

  always_comb begin
    state_nxt  = cur;
    status_nxt = ST_ACCEPTED;
    priority if (s1_op_r == OP_RESET) begin
      state_nxt = '0;
    end else if (s1_seq_r < cur.expected) begin
      status_nxt = ST_DUPLICATE;
    end else if (s1_seq_r == cur.expected) begin
      state_nxt.expected = s1_seq_r + SEQ_W'(run) + 32'd1;
      state_nxt.highest  = seq_max;
      state_nxt.pending  = cur.pending >> shift_amt;
    end else if (gap > max_gap_r) begin
      state_nxt.expected = s1_seq_r + 32'd1;
      state_nxt.highest  = s1_seq_r;
      state_nxt.pending  = '0;
      status_nxt         = ST_RESYNC;
    end else if (gap <= SEQ_W'(tol_eff)) begin
      state_nxt.pending  = cur.pending | ({{(WINDOW-1){1'b0}}, 1'b1} << gap_idx);
      state_nxt.highest  = seq_max;
      status_nxt         = ST_REORDERED;
    end else begin
      status_nxt = ST_TOO_FAR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CONN; i++) begin
        state_r[i] <= '0;
      end
    end else if (s1_fire) begin
      state_r[s1_conn_r] <= state_nxt;
    end
  end

  // Result register.
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [SEQ_W-1:0]    out_expected_r;
  logic [SEQ_W-1:0]    out_highest_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_status_r   <= status_nxt;
      out_expected_r <= state_nxt.expected;
      out_highest_r  <= state_nxt.highest;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_expected_next = out_expected_r;
  assign out_highest_seen  = out_highest_r;

`ifndef SYNTHESIS
  // A connection reset reports accepted with cleared numbers.
  a_reset_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_op_r == OP_RESET |=>
      out_status_r == ST_ACCEPTED && out_expected_r == '0 && out_highest_r == '0)
    else $error("connection reset result is not cleared");

  // After a resync, expected sits right past the highest number seen.
  a_resync_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == ST_RESYNC |->
      out_expected_r == out_highest_r + 32'd1)
    else $error("resync result is inconsistent");

  // A waiting item keeps its contents while the result register is stalled.
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !advance |=>
      s1_valid_r && $stable(s1_seq_r) && $stable(s1_conn_r) && $stable(s1_op_r))
    else $error("input register changed while stalled");

  // The late-accept code is never produced, and no code beyond too-far appears.
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_status_r != ST_ACCEPTED_LATE && out_status_r <= ST_TOO_FAR)
    else $error("illegal status code");
`endif

endmodule

`default_nettype wire
